// ----- hw/rtl/dcb_pkg.sv -----
// Package for the descriptor chain builder: sizes, codes, item and command types.
// Used by every module of the block and by its port checker.
`default_nettype none

package dcb_pkg;

    localparam int DESC_PAGES_MAX  = 8;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int XFER_PAGE_BYTES = 4096;
    localparam int DESC_BYTES      = 20;
    localparam int RESULT_CAP      = 64;

    localparam int TBL_IDX_W  = $clog2(DESC_PAGES_MAX);
    localparam int TBL_CNT_W  = $clog2(DESC_PAGES_MAX + 1);
    localparam int XFER_SHIFT = $clog2(XFER_PAGE_BYTES);
    localparam int PAGES_LIM  = (PAGES_PER_BLOCK < RESULT_CAP - 1) ?
                                PAGES_PER_BLOCK : RESULT_CAP - 1;
    localparam int PAGES_W    = $clog2(PAGES_LIM + 1);
    localparam int SIZE_W     = 18;
    localparam int SPACE_W    = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SPACE_W-1:0] SPACE_MAX  = '1;
    localparam logic [SPACE_W-1:0] DESC_STEP  = SPACE_W'(DESC_BYTES);
    localparam logic [63:0]        XFER_STEP  = 64'(XFER_PAGE_BYTES);
    localparam logic [31:0]        LEN_WORD   = 32'(XFER_PAGE_BYTES) | 32'd7;
    localparam logic [63:0]        DATA_FLAGS = 64'd7;
    localparam logic [63:0]        LINK_FLAG  = 64'd2;
    localparam logic [63:0]        LINK_END   = 64'd1;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_BLOCK  = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FILLED    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_BLOCK,
        CMD_FINISH
    } t_cmd_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BLOCK,
        S_FILL
    } t_back_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [63:0]       addr;
        logic [SIZE_W-1:0] size;
    } t_in_item;

    typedef struct packed {
        logic [63:0] desc_loc;
        logic [63:0] data_word;
        logic [31:0] length_word;
        logic [63:0] next_link;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    // Classified command: arg holds the saturated page size for a load and
    // the page count for a block.
    typedef struct packed {
        t_cmd_kind          kind;
        logic [63:0]        addr;
        logic [SPACE_W-1:0] arg;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

endpackage

`default_nettype wire

// ----- hw/rtl/dcb_front.sv -----
// Front end of the descriptor chain builder: accepts input items, classifies them
// into commands and holds them in a short queue. Depends on dcb_pkg.
`default_nettype none

module dcb_front
    import dcb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output t_cmd_head      o_head,
    input  wire logic      i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;

    t_cmd               cmd;
    logic               push;
    logic               keep;
    logic [PAGES_W-1:0] pages;
    logic [SIZE_W-XFER_SHIFT-1:0] raw_pages;

    always_comb begin
        raw_pages = i_in_item.size[SIZE_W-1:XFER_SHIFT];
        if (32'(raw_pages) > 32'(PAGES_LIM)) begin
            pages = PAGES_W'(PAGES_LIM);
        end else begin
            pages = PAGES_W'(raw_pages);
        end

        cmd.addr = i_in_item.addr;
        cmd.arg  = SPACE_W'(pages);
        cmd.kind = CMD_LOAD;
        keep     = 1'b1;
        unique case (t_req'(i_in_item.req_type))
            REQ_LOAD: begin
                cmd.kind = CMD_LOAD;
                // saturate oversized descriptor pages
                if (i_in_item.size > SIZE_W'(SPACE_MAX)) begin
                    cmd.arg = SPACE_MAX;
                end else begin
                    cmd.arg = i_in_item.size[SPACE_W-1:0];
                end
            end
            REQ_BLOCK:  cmd.kind = CMD_BLOCK;
            REQ_FINISH: cmd.kind = CMD_FINISH;
            REQ_NONE:   keep = 1'b0;    // drop unknown requests
        endcase
    end

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready && keep;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop && o_head.valid) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !(i_pop && o_head.valid)) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop && o_head.valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rptr];

endmodule

`default_nettype wire

// ----- hw/rtl/dcb_back.sv -----
// Back end of the descriptor chain builder: page table, chain state, the page walk
// sequencer and the output register. Depends on dcb_pkg.
`default_nettype none

module dcb_back
    import dcb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_head i_head,
    output logic           o_pop,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic [63:0]        r_tbl_addr [DESC_PAGES_MAX];
    logic [SPACE_W-1:0] r_tbl_size [DESC_PAGES_MAX];

    t_back_state        r_state, n_state;
    logic [TBL_CNT_W-1:0] r_pages_loaded, n_pages_loaded;
    logic [TBL_CNT_W-1:0] r_page_index, n_page_index;
    logic [63:0]        r_slot_addr, n_slot_addr;
    logic [SPACE_W-1:0] r_space_left, n_space_left;
    logic               r_pending_valid, n_pending_valid;
    logic [63:0]        r_pending_desc, n_pending_desc;
    logic [63:0]        r_pending_page, n_pending_page;
    logic               r_aborted, n_aborted;
    logic [PAGES_W-1:0] r_pages_left, n_pages_left;
    logic [63:0]        r_pa, n_pa;
    logic               r_loop_mode;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               out_free;
    logic               emit;
    logic               tbl_we;
    t_out_item          item;
    logic [SPACE_W-1:0] space_after;
    logic [TBL_IDX_W-1:0] rd_idx;

    assign out_free    = !r_out_valid || i_out_ready;
    assign space_after = r_space_left - DESC_STEP;
    assign rd_idx      = r_page_index[TBL_IDX_W-1:0];

    always_comb begin
        n_state         = r_state;
        n_pages_loaded  = r_pages_loaded;
        n_page_index    = r_page_index;
        n_slot_addr     = r_slot_addr;
        n_space_left    = r_space_left;
        n_pending_valid = r_pending_valid;
        n_pending_desc  = r_pending_desc;
        n_pending_page  = r_pending_page;
        n_aborted       = r_aborted;
        n_pages_left    = r_pages_left;
        n_pa            = r_pa;
        o_pop           = 1'b0;
        emit            = 1'b0;
        tbl_we          = 1'b0;

        item.desc_loc    = r_pending_desc;
        item.data_word   = r_pending_page | DATA_FLAGS;
        item.length_word = LEN_WORD;
        item.next_link   = LINK_FLAG;
        item.status      = ST_OK;
        item.last        = 1'b1;

        if (out_free) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        o_pop = 1'b1;
                        unique case (i_head.cmd.kind)
                            CMD_LOAD: begin
                                if (r_pages_loaded < TBL_CNT_W'(DESC_PAGES_MAX)) begin
                                    tbl_we         = 1'b1;
                                    n_pages_loaded = r_pages_loaded + 1'b1;
                                end
                            end
                            CMD_BLOCK: begin
                                if (!r_aborted && i_head.cmd.arg != '0) begin
                                    n_pages_left = PAGES_W'(i_head.cmd.arg);
                                    n_pa         = i_head.cmd.addr;
                                    n_state      = S_BLOCK;
                                end
                            end
                            CMD_FINISH: begin
                                if (r_pending_valid && !r_aborted) begin
                                    emit = 1'b1;
                                    item.next_link = (r_loop_mode ? r_tbl_addr[0] : LINK_END)
                                                     | LINK_FLAG;
                                end
                                // restart the chain, keep the loaded pages
                                n_page_index    = '0;
                                n_slot_addr     = '0;
                                n_space_left    = '0;
                                n_pending_valid = 1'b0;
                                n_pending_desc  = '0;
                                n_pending_page  = '0;
                                n_aborted       = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BLOCK: begin
                    if (r_space_left < DESC_STEP) begin
                        if (r_page_index >= r_pages_loaded) begin
                            // out of descriptor pages
                            emit        = 1'b1;
                            item.status = ST_EXHAUSTED;
                            if (!r_pending_valid) begin
                                item.desc_loc    = '0;
                                item.data_word   = '0;
                                item.length_word = '0;
                            end
                            n_pending_valid = 1'b0;
                            n_aborted       = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            n_slot_addr  = r_tbl_addr[rd_idx];
                            n_space_left = r_tbl_size[rd_idx];
                            n_page_index = r_page_index + 1'b1;
                        end
                    end else begin
                        emit           = r_pending_valid;
                        item.next_link = r_slot_addr | LINK_FLAG;
                        item.last      = (r_pages_left == PAGES_W'(1)) && (space_after != '0);
                        n_pending_desc  = r_slot_addr;
                        n_pending_page  = r_pa;
                        n_pending_valid = 1'b1;
                        n_pa            = r_pa + XFER_STEP;
                        n_space_left    = space_after;
                        n_pages_left    = r_pages_left - 1'b1;
                        if (space_after == '0) begin
                            n_state = S_FILL;
                        end else begin
                            n_slot_addr = r_slot_addr + 64'(DESC_BYTES);
                            if (r_pages_left == PAGES_W'(1)) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
                S_FILL: begin
                    // page used to its last byte: close with an error
                    emit            = 1'b1;
                    item.status     = ST_FILLED;
                    n_pending_valid = 1'b0;
                    n_aborted       = 1'b1;
                    n_state         = S_IDLE;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_pages_loaded  <= '0;
            r_page_index    <= '0;
            r_slot_addr     <= '0;
            r_space_left    <= '0;
            r_pending_valid <= 1'b0;
            r_pending_desc  <= '0;
            r_pending_page  <= '0;
            r_aborted       <= 1'b0;
            r_pages_left    <= '0;
            r_pa            <= '0;
            r_loop_mode     <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_pages_loaded  <= n_pages_loaded;
            r_page_index    <= n_page_index;
            r_slot_addr     <= n_slot_addr;
            r_space_left    <= n_space_left;
            r_pending_valid <= n_pending_valid;
            r_pending_desc  <= n_pending_desc;
            r_pending_page  <= n_pending_page;
            r_aborted       <= n_aborted;
            r_pages_left    <= n_pages_left;
            r_pa            <= n_pa;
            if (i_cfg_valid) begin
                r_loop_mode <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= item;
        end
        if (tbl_we) begin
            r_tbl_addr[r_pages_loaded[TBL_IDX_W-1:0]] <= i_head.cmd.addr;
            r_tbl_size[r_pages_loaded[TBL_IDX_W-1:0]] <= i_head.cmd.arg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- hw/rtl/dma_descriptor_chain_builder.sv -----
// Top level of the descriptor chain builder: front end, command queue, back end.
// Depends on dcb_pkg, dcb_front and dcb_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item): load descriptor pages
//   first, then send buffer blocks, then a finish item to close the chain.
//   Output channel (o_out_valid / i_out_ready / o_out_item): one descriptor per
//   transfer, with last marking the final result caused by an input item.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): loop mode, always
//   ready; write it only while the block is idle.
// Flow:
//   An item enters a two-entry queue and is registered there before the back
//   end sees it. Loads and finishes are handled in the idle state; a block of
//   at most 63 pages starts there, then the page walk sequencer forms one
//   descriptor per cycle while the output register is free, opens a descriptor
//   page when space runs out and ends with an error result if pages run out or
//   one fills. A finish result is valid in the cycle after its pop.
// Reset: synchronous, active low; clears the chain, the loaded page count and
//   sets loop mode. The page table itself is not cleared.
// Stalls: the output register holds a result until taken; the back end waits,
//   and the front keeps accepting until its queue is full.
`default_nettype none

module dma_descriptor_chain_builder
    import dcb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);

    t_cmd_head head;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    dcb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    dcb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dcb_port_checker.sv -----
// Port checker for the descriptor chain builder, bound to the top level.
// Depends on dcb_pkg and dma_descriptor_chain_builder.
`default_nettype none

module dcb_port_checker
    import dcb_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // every error result closes its input item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.last)
        else $error("error result not marked last");

    a_err_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.next_link == LINK_FLAG)
        else $error("error result with a live link");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_OK |->
            o_out_item.length_word == LEN_WORD && o_out_item.next_link[1]
            && o_out_item.data_word[2:0] == 3'd7)
        else $error("descriptor words malformed");

endmodule

bind dma_descriptor_chain_builder dcb_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
